/* sv/character_lcd_controller_top_assert.svh */
// Assertion macros for the character LCD controller top level.
// Expects signals named clk and rst_n in the scope of use.
`ifndef CHARACTER_LCD_CONTROLLER_TOP_ASSERT_SVH
`define CHARACTER_LCD_CONTROLLER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CHLCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CHLCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHLCD_ASSERT_IMP(lbl, ante, cons, msg)
`define CHLCD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/chlcd_pkg.sv */
// Shared types, codes and defaults for the character LCD controller.
// No dependencies.
`default_nettype none

package chlcd_pkg;

    localparam int LINE_LENGTH_DEF   = 40;
    localparam int GLYPH_DEPTH_DEF   = 64;
    localparam int VISIBLE_CELLS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam int LINE2_BASE = 'h40;

    localparam logic [7:0]  SPACE_CHAR = 8'h20;
    localparam logic [7:0]  BUSY_BIT   = 8'h80;
    localparam logic [15:0] BUSY_MAX   = 16'hFFFF;

    localparam logic [15:0] CLEAR_BUSY_RESET   = 16'd1520;
    localparam logic [15:0] COMMAND_BUSY_RESET = 16'd37;
    localparam logic [15:0] BUSY_EXTEND_RESET  = 16'd20;

    localparam logic [1:0] CFG_CLEAR_BUSY   = 2'd0;
    localparam logic [1:0] CFG_COMMAND_BUSY = 2'd1;
    localparam logic [1:0] CFG_BUSY_EXTEND  = 2'd2;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_FOUR_BIT = 2'd1;
    localparam logic [1:0] ERR_ONE_LINE = 2'd2;

    localparam logic [3:0] OP_TICK    = 4'd0;
    localparam logic [3:0] OP_STATUS  = 4'd1;
    localparam logic [3:0] OP_DATA    = 4'd2;
    localparam logic [3:0] OP_NOP     = 4'd3;
    localparam logic [3:0] OP_CLEAR   = 4'd4;
    localparam logic [3:0] OP_HOME    = 4'd5;
    localparam logic [3:0] OP_ENTRY   = 4'd6;
    localparam logic [3:0] OP_DISPLAY = 4'd7;
    localparam logic [3:0] OP_SHIFT   = 4'd8;
    localparam logic [3:0] OP_FUNC    = 4'd9;
    localparam logic [3:0] OP_CGRAM   = 4'd10;
    localparam logic [3:0] OP_DDRAM   = 4'd11;

    typedef struct packed {
        logic [3:0]  op;
        logic        rw;
        logic [7:0]  data;
        logic [15:0] elapsed;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

`default_nettype wire

/* sv/chlcd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module chlcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/chlcd_queue.sv */
// Short FIFO of decoded beats between front and back.
// Depends on chlcd_pkg.
`default_nettype none

module chlcd_queue #(
    parameter int DEPTH = chlcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  chlcd_pkg::item_t  push_item,
    input  logic              pop,
    output chlcd_pkg::item_t  head_item,
    output chlcd_pkg::qstat_t qstat
);
    import chlcd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    item_t          mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item   = mem_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == FULL_CNT);
    assign qstat.empty = (count_reg == '0);

endmodule

`default_nettype wire

/* sv/chlcd_front.sv */
// Front end: accepts bus beats and classifies them into operation codes.
// Depends on chlcd_pkg.
`default_nettype none

module chlcd_front (
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             mode,
    input  logic             register_select,
    input  logic             read_not_write,
    input  logic [7:0]       bus_data,
    input  logic [15:0]      elapsed_us,
    input  logic             q_full,
    output logic             push,
    output chlcd_pkg::item_t item
);
    import chlcd_pkg::*;

    logic [3:0] cmd_op;

    // command decoded by highest set bit
    always_comb
    begin
        if (bus_data[7])      cmd_op = OP_DDRAM;
        else if (bus_data[6]) cmd_op = OP_CGRAM;
        else if (bus_data[5]) cmd_op = OP_FUNC;
        else if (bus_data[4]) cmd_op = OP_SHIFT;
        else if (bus_data[3]) cmd_op = OP_DISPLAY;
        else if (bus_data[2]) cmd_op = OP_ENTRY;
        else if (bus_data[1]) cmd_op = OP_HOME;
        else if (bus_data[0]) cmd_op = OP_CLEAR;
        else                  cmd_op = OP_NOP;
    end

    always_comb
    begin
        item.rw      = read_not_write;
        item.data    = bus_data;
        item.elapsed = elapsed_us;
        if (!mode)                item.op = OP_TICK;
        else if (register_select) item.op = OP_DATA;
        else if (read_not_write)  item.op = OP_STATUS;
        else                      item.op = cmd_op;
    end

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

endmodule

`default_nettype wire

/* sv/chlcd_back.sv */
// Back end: controller state, display and glyph RAMs, busy timer, result register.
// Depends on chlcd_pkg and chlcd_ram.
`default_nettype none

module chlcd_back #(
    parameter int LINE_LENGTH   = chlcd_pkg::LINE_LENGTH_DEF,
    parameter int GLYPH_DEPTH   = chlcd_pkg::GLYPH_DEPTH_DEF,
    parameter int VISIBLE_CELLS = chlcd_pkg::VISIBLE_CELLS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             q_empty,
    input  chlcd_pkg::item_t item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       read_data,
    output logic             was_busy,
    output logic [1:0]       error_code,
    output logic             display_enabled,
    output logic             cursor_visible,
    output logic             cursor_blinking,
    output logic [3:0]       cursor_column,
    output logic [5:0]       display_offset,
    output logic             cursor_on_first_line
);
    import chlcd_pkg::*;

    localparam int DD_DEPTH = 2 * LINE_LENGTH;
    localparam int DD_AW    = $clog2(DD_DEPTH);
    localparam int GL_AW    = $clog2(GLYPH_DEPTH);
    localparam int CELL_W   = $clog2(VISIBLE_CELLS);

    localparam logic [7:0] LL_8        = 8'(LINE_LENGTH);
    localparam logic [7:0] LL_LAST_8   = 8'(LINE_LENGTH - 1);
    localparam logic [7:0] L2_BASE_8   = 8'(LINE2_BASE);
    localparam logic [7:0] L2_PREV_8   = 8'(LINE2_BASE - 1);
    localparam logic [7:0] L2_END_8    = 8'(LINE2_BASE + LINE_LENGTH);
    localparam logic [7:0] L2_LAST_8   = 8'(LINE2_BASE + LINE_LENGTH - 1);
    localparam logic [7:0] GD_8        = 8'(GLYPH_DEPTH);
    localparam logic [5:0] SHIFT_LAST  = 6'(LINE_LENGTH - 1);
    localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(VISIBLE_CELLS - 1);

    localparam logic S_EXEC = 1'b0;
    localparam logic S_FIN  = 1'b1;

    logic        state_reg, state_next;

    logic [15:0] clear_busy_reg, command_busy_reg, busy_extend_reg;

    logic [7:0]        ac_reg, ac_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [5:0]        shift_reg, shift_next;
    logic              first_reg, first_next;
    logic              gsel_reg, gsel_next;
    logic              inc_reg, inc_next;
    logic              shf_reg, shf_next;
    logic [2:0]        disp_reg, disp_next;
    logic              eight_reg, eight_next;
    logic [15:0]       busy_reg, busy_next;
    logic [DD_DEPTH-1:0]    dd_valid_reg, dd_valid_next;
    logic [GLYPH_DEPTH-1:0] gl_valid_reg, gl_valid_next;

    logic [7:0] pend_rd_reg, pend_rd_next;
    logic       pend_busy_reg, pend_busy_next;
    logic [1:0] pend_err_reg, pend_err_next;
    logic       pend_ram_reg, pend_ram_next;
    logic       pend_valid_reg, pend_valid_next;
    logic       pend_glyph_reg, pend_glyph_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] rd_out_reg;
    logic       busy_out_reg;
    logic [1:0] err_out_reg;

    logic              busy;
    logic [16:0]       ext_sum;
    logic [15:0]       busy_ext;
    logic              dd_hit1, dd_hit2, dd_hit, gl_hit;
    logic [7:0]        dd_off, dd_lin, ac_step, dd_cmd_ac;
    logic [DD_AW-1:0]  dd_idx;
    logic [GL_AW-1:0]  gl_idx;
    logic              dd_we, dd_re, gl_we, gl_re;
    logic [7:0]        dd_q, gl_q, ram_byte;
    logic              load;
    logic [CELL_W+3:0] cell_ext;

    assign busy     = (busy_reg != '0);
    assign ext_sum  = {1'b0, busy_reg} + {1'b0, busy_extend_reg};
    assign busy_ext = ext_sum[16] ? BUSY_MAX : ext_sum[15:0];

    assign dd_hit1 = (ac_reg < LL_8);
    assign dd_hit2 = (ac_reg >= L2_BASE_8) && (ac_reg < L2_END_8);
    assign dd_hit  = dd_hit1 || dd_hit2;
    assign dd_off  = ac_reg - L2_BASE_8 + LL_8;
    assign dd_lin  = dd_hit1 ? ac_reg : dd_off;
    assign dd_idx  = dd_lin[DD_AW-1:0];
    assign gl_hit  = (ac_reg < GD_8);
    assign gl_idx  = ac_reg[GL_AW-1:0];
    assign dd_cmd_ac = {1'b0, item.data[6:0]};

    // a waiting result holds the back so the live flag fields stay put
    assign pop  = (state_reg == S_EXEC) && !q_empty && (!out_valid_reg || out_ready);
    assign load = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next      = state_reg;
        ac_next         = ac_reg;
        cell_next       = cell_reg;
        shift_next      = shift_reg;
        first_next      = first_reg;
        gsel_next       = gsel_reg;
        inc_next        = inc_reg;
        shf_next        = shf_reg;
        disp_next       = disp_reg;
        eight_next      = eight_reg;
        busy_next       = busy_reg;
        dd_valid_next   = dd_valid_reg;
        gl_valid_next   = gl_valid_reg;
        pend_rd_next    = pend_rd_reg;
        pend_busy_next  = pend_busy_reg;
        pend_err_next   = pend_err_reg;
        pend_ram_next   = pend_ram_reg;
        pend_valid_next = pend_valid_reg;
        pend_glyph_next = pend_glyph_reg;
        dd_we           = 1'b0;
        dd_re           = 1'b0;
        gl_we           = 1'b0;
        gl_re           = 1'b0;
        ac_step         = ac_reg;

        if (pop)
        begin
            state_next      = S_FIN;
            pend_rd_next    = item.data;
            pend_busy_next  = busy;
            pend_err_next   = ERR_OK;
            pend_ram_next   = 1'b0;
            pend_valid_next = 1'b0;
            pend_glyph_next = gsel_reg;
            case (item.op)
                OP_TICK:
                begin
                    busy_next = (item.elapsed >= busy_reg) ? '0 : busy_reg - item.elapsed;
                end
                OP_STATUS:
                begin
                    if (!eight_reg)
                        pend_err_next = ERR_FOUR_BIT;
                    else
                        pend_rd_next = ac_reg | (busy ? BUSY_BIT : 8'h00);
                end
                OP_DATA:
                begin
                    if (!eight_reg)
                    begin
                        pend_err_next = ERR_FOUR_BIT;
                    end
                    else if (busy)
                    begin
                        busy_next = busy_ext;
                    end
                    else
                    begin
                        busy_next = command_busy_reg;
                        if (gsel_reg)
                        begin
                            if (item.rw)
                            begin
                                pend_rd_next    = 8'h00;
                                pend_ram_next   = gl_hit;
                                pend_valid_next = gl_hit && gl_valid_reg[gl_idx];
                                gl_re           = gl_hit;
                            end
                            else if (gl_hit)
                            begin
                                gl_we                 = 1'b1;
                                gl_valid_next[gl_idx] = 1'b1;
                            end
                        end
                        else
                        begin
                            if (item.rw)
                            begin
                                pend_rd_next    = 8'h00;
                                pend_ram_next   = dd_hit;
                                pend_valid_next = dd_hit && dd_valid_reg[dd_idx];
                                dd_re           = dd_hit;
                            end
                            else if (dd_hit)
                            begin
                                dd_we                 = 1'b1;
                                dd_valid_next[dd_idx] = 1'b1;
                            end
                        end
                        if (inc_reg)
                        begin
                            if (shf_reg)
                                shift_next = (shift_reg == SHIFT_LAST) ? '0 : shift_reg + 1'b1;
                            else if (cell_reg < CELL_LAST)
                                cell_next = cell_reg + 1'b1;
                            ac_step = ac_reg + 8'd1;
                        end
                        else
                        begin
                            if (shf_reg)
                                shift_next = (shift_reg == '0) ? SHIFT_LAST : shift_reg - 1'b1;
                            else if (cell_reg != '0)
                                cell_next = cell_reg - 1'b1;
                            ac_step = ac_reg - 8'd1;
                        end
                        ac_next = ac_step;
                        if (first_reg)
                        begin
                            if (ac_step == 8'hFF)
                                ac_next = LL_LAST_8;
                            else if (ac_step == LL_8)
                                ac_next = 8'h00;
                        end
                        else
                        begin
                            if (ac_step == L2_PREV_8)
                                ac_next = L2_LAST_8;
                            else if (ac_step == L2_END_8)
                                ac_next = L2_BASE_8;
                        end
                    end
                end
                default:
                begin
                    if (busy)
                    begin
                        busy_next = busy_ext;
                    end
                    else if (!eight_reg)
                    begin
                        pend_err_next = ERR_FOUR_BIT;
                    end
                    else
                    begin
                        case (item.op)
                            OP_CLEAR:
                            begin
                                gsel_next     = 1'b0;
                                dd_valid_next = '0;
                                ac_next       = 8'h00;
                                cell_next     = '0;
                                first_next    = 1'b1;
                                busy_next     = clear_busy_reg;
                            end
                            OP_HOME:
                            begin
                                gsel_next  = 1'b0;
                                ac_next    = 8'h00;
                                cell_next  = '0;
                                first_next = 1'b1;
                                shift_next = '0;
                                busy_next  = clear_busy_reg;
                            end
                            OP_ENTRY:
                            begin
                                gsel_next = 1'b0;
                                inc_next  = item.data[1];
                                shf_next  = item.data[0];
                                busy_next = command_busy_reg;
                            end
                            OP_DISPLAY:
                            begin
                                gsel_next = 1'b0;
                                disp_next = item.data[2:0];
                                busy_next = command_busy_reg;
                            end
                            OP_SHIFT:
                            begin
                                gsel_next = 1'b0;
                                shf_next  = item.data[3];
                                inc_next  = item.data[2];
                                busy_next = command_busy_reg;
                            end
                            OP_FUNC:
                            begin
                                eight_next = item.data[4];
                                if (!item.data[3])
                                    pend_err_next = ERR_ONE_LINE;
                                else
                                    busy_next = command_busy_reg;
                            end
                            OP_CGRAM:
                            begin
                                ac_next   = {2'b00, item.data[5:0]};
                                gsel_next = 1'b1;
                                busy_next = command_busy_reg;
                            end
                            OP_DDRAM:
                            begin
                                ac_next = dd_cmd_ac;
                                if (dd_cmd_ac < LL_8)
                                begin
                                    first_next = 1'b1;
                                    shift_next = dd_cmd_ac[5:0];
                                end
                                else if ((dd_cmd_ac >= L2_BASE_8) && (dd_cmd_ac < L2_END_8))
                                begin
                                    first_next = 1'b0;
                                    shift_next = 6'(dd_cmd_ac - L2_BASE_8);
                                end
                                gsel_next = 1'b0;
                                busy_next = command_busy_reg;
                            end
                            default:
                            begin
                                busy_next = busy_reg;
                            end
                        endcase
                    end
                end
            endcase
        end
        else if (load)
        begin
            state_next = S_EXEC;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
            out_valid_next = 1'b1;
    end

    // unwritten entries read as their cleared value
    always_comb
    begin
        if (pend_valid_reg)
            ram_byte = pend_glyph_reg ? gl_q : dd_q;
        else
            ram_byte = pend_glyph_reg ? 8'h00 : SPACE_CHAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_EXEC;
            out_valid_reg    <= 1'b0;
            clear_busy_reg   <= CLEAR_BUSY_RESET;
            command_busy_reg <= COMMAND_BUSY_RESET;
            busy_extend_reg  <= BUSY_EXTEND_RESET;
            ac_reg           <= 8'h00;
            cell_reg         <= '0;
            shift_reg        <= '0;
            first_reg        <= 1'b1;
            gsel_reg         <= 1'b0;
            inc_reg          <= 1'b1;
            shf_reg          <= 1'b0;
            disp_reg         <= '0;
            eight_reg        <= 1'b1;
            busy_reg         <= '0;
            dd_valid_reg     <= '0;
            gl_valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLEAR_BUSY:   clear_busy_reg   <= cfg_data;
                    CFG_COMMAND_BUSY: command_busy_reg <= cfg_data;
                    CFG_BUSY_EXTEND:  busy_extend_reg  <= cfg_data;
                    default:          busy_extend_reg  <= busy_extend_reg;
                endcase
            end
            ac_reg       <= ac_next;
            cell_reg     <= cell_next;
            shift_reg    <= shift_next;
            first_reg    <= first_next;
            gsel_reg     <= gsel_next;
            inc_reg      <= inc_next;
            shf_reg      <= shf_next;
            disp_reg     <= disp_next;
            eight_reg    <= eight_next;
            busy_reg     <= busy_next;
            dd_valid_reg <= dd_valid_next;
            gl_valid_reg <= gl_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_rd_reg    <= pend_rd_next;
        pend_busy_reg  <= pend_busy_next;
        pend_err_reg   <= pend_err_next;
        pend_ram_reg   <= pend_ram_next;
        pend_valid_reg <= pend_valid_next;
        pend_glyph_reg <= pend_glyph_next;
        if (load)
        begin
            rd_out_reg   <= pend_ram_reg ? ram_byte : pend_rd_reg;
            busy_out_reg <= pend_busy_reg;
            err_out_reg  <= pend_err_reg;
        end
    end

    chlcd_ram #(
        .WIDTH (8),
        .DEPTH (DD_DEPTH)
    ) u_display_ram (
        .clk   (clk),
        .we    (dd_we),
        .waddr (dd_idx),
        .wdata (item.data),
        .re    (dd_re),
        .raddr (dd_idx),
        .rdata (dd_q)
    );

    chlcd_ram #(
        .WIDTH (8),
        .DEPTH (GLYPH_DEPTH)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (gl_we),
        .waddr (gl_idx),
        .wdata (item.data),
        .re    (gl_re),
        .raddr (gl_idx),
        .rdata (gl_q)
    );

    // flag fields follow live state; no item runs until the result beat is taken
    assign cell_ext             = {4'b0000, cell_reg};
    assign out_valid            = out_valid_reg;
    assign read_data            = rd_out_reg;
    assign was_busy             = busy_out_reg;
    assign error_code           = err_out_reg;
    assign display_enabled      = disp_reg[2];
    assign cursor_visible       = disp_reg[1];
    assign cursor_blinking      = disp_reg[0];
    assign cursor_column        = cell_ext[3:0];
    assign display_offset       = shift_reg;
    assign cursor_on_first_line = first_reg;

endmodule

`default_nettype wire

/* sv/character_lcd_controller_top.sv */
// Top level of the two-line character LCD controller, 8-bit bus mode.
// Depends on chlcd_pkg, chlcd_front, chlcd_queue, chlcd_back and the assertion header.
`default_nettype none
`include "character_lcd_controller_top_assert.svh"

// Each input beat is a time tick or one bus strobe and yields exactly one result
// beat. The front takes a beat in any cycle the decoded-beat queue has room; the
// back runs each beat through an execute state (execute and RAM read) and a finish
// state (load of the result register), set by the registered read of the display
// and glyph RAMs; no new beat runs before that load. A full result register stalls the
// back only; the queue keeps accepting. A clear command blanks the display RAM at
// once through per-entry valid flags, so there is no clearing pass after reset or
// clear. Configuration writes are taken at any edge with cfg_we high.
module character_lcd_controller_top #(
    parameter int LINE_LENGTH   = chlcd_pkg::LINE_LENGTH_DEF,
    parameter int GLYPH_DEPTH   = chlcd_pkg::GLYPH_DEPTH_DEF,
    parameter int VISIBLE_CELLS = chlcd_pkg::VISIBLE_CELLS_DEF,
    parameter int QUEUE_DEPTH   = chlcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic        register_select,
    input  logic        read_not_write,
    input  logic [7:0]  bus_data,
    input  logic [15:0] elapsed_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        was_busy,
    output logic [1:0]  error_code,
    output logic        display_enabled,
    output logic        cursor_visible,
    output logic        cursor_blinking,
    output logic [3:0]  cursor_column,
    output logic [5:0]  display_offset,
    output logic        cursor_on_first_line
);
    import chlcd_pkg::*;

    logic   push;
    logic   pop;
    item_t  in_item;
    item_t  head_item;
    qstat_t qstat;

    chlcd_front u_front (
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .register_select (register_select),
        .read_not_write  (read_not_write),
        .bus_data        (bus_data),
        .elapsed_us      (elapsed_us),
        .q_full          (qstat.full),
        .push            (push),
        .item            (in_item)
    );

    chlcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (in_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    chlcd_back #(
        .LINE_LENGTH   (LINE_LENGTH),
        .GLYPH_DEPTH   (GLYPH_DEPTH),
        .VISIBLE_CELLS (VISIBLE_CELLS)
    ) u_back (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .q_empty              (qstat.empty),
        .item                 (head_item),
        .pop                  (pop),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .read_data            (read_data),
        .was_busy             (was_busy),
        .error_code           (error_code),
        .display_enabled      (display_enabled),
        .cursor_visible       (cursor_visible),
        .cursor_blinking      (cursor_blinking),
        .cursor_column        (cursor_column),
        .display_offset       (display_offset),
        .cursor_on_first_line (cursor_on_first_line)
    );

    `CHLCD_ASSERT_IMP(a_push_room, push, !qstat.full, "beat pushed into full queue")
    `CHLCD_ASSERT_IMP(a_pop_data, pop, !qstat.empty, "pop from empty queue")
    `CHLCD_ASSERT_NXT(a_pop_spacing, pop, !pop, "back popped on consecutive cycles")
    `CHLCD_ASSERT_IMP(a_pop_out_free, pop, !out_valid || out_ready,
        "back took a new beat while a result beat waits")

endmodule

`default_nettype wire
